// ===== rtl/core/ansi_escape_text_screen_unit_macros.svh =====
// Assertion macros shared by the screen unit checker.
`ifndef ANSI_ESCAPE_TEXT_SCREEN_UNIT_MACROS_SVH
`define ANSI_ESCAPE_TEXT_SCREEN_UNIT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define AETS_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define AETS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== rtl/core/aets_pkg.sv =====
// Package with types and constants of the ANSI text screen unit.
`default_nettype none
package aets_pkg;
  localparam logic [7:0] EscByte     = 8'd27;
  localparam logic [7:0] SpaceByte   = 8'd32;
  localparam logic [7:0] LfByte      = 8'd10;
  localparam logic [7:0] AttrDefault = 8'd7;
  localparam logic [7:0] ForeKeep    = 8'hf8;
  localparam logic [7:0] BackKeep    = 8'h8f;
  localparam logic [7:0] AttrBlink   = 8'd128;
  localparam logic [7:0] AttrIntense = 8'd8;
  localparam logic       OpFeed      = 1'b0;
  localparam logic       OpRead      = 1'b1;

  typedef enum logic [1:0] {
    PS_TEXT = 2'd0,
    PS_ESC  = 2'd1,
    PS_CSI  = 2'd2
  } parse_e;

  // Map of color number to r,g,b attribute bits.
  function automatic logic [2:0] colour_bits(input logic [2:0] c);
    logic [2:0] r;
    case (c)
      3'd0: r = 3'd0;
      3'd1: r = 3'd4;
      3'd2: r = 3'd2;
      3'd3: r = 3'd6;
      3'd4: r = 3'd1;
      3'd5: r = 3'd5;
      3'd6: r = 3'd3;
      default: r = 3'd7;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

// ===== rtl/core/aets_ram.sv =====
// Generic single-port RAM with registered read.
`default_nettype none
module aets_ram #(
  parameter int Width = 8,
  parameter int Depth = 2000
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // One access per cycle; read data registered.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

// ===== rtl/core/ansi_escape_text_screen_unit.sv =====
// Top level of the ANSI escape text screen unit.
// Usage: the input channel carries operation, data_byte, read_column and
// read_row; the output channel returns one beat per input beat with the
// read cell (zero for feeds), the one-based cursor and the halted flag.
// Both channels use valid and stall; a beat moves when valid is high and
// stall is low.
// The unit takes one beat at a time. A printable byte passes through the
// address, clear and output states; a byte that only steps the parser, or
// any byte while halted, goes from address to output; a read passes address,
// RAM wait, read data and output. An SGR sequence end applies one parameter
// per cycle in the shared attribute unit. Clear screen walks all COLUMNS*ROWS
// cells, one per cycle, and clear line walks the rest of the row.
// After reset a clearing pass writes spaces and zero attributes into all
// COLUMNS*ROWS cells of both stores; no input beat is taken meanwhile.
// When the receiver stalls, the result holds in the output register and
// the unit takes no new beat until it is delivered.
`default_nettype none
module ansi_escape_text_screen_unit
  import aets_pkg::*;
#(
  parameter int COLUMNS    = 80,
  parameter int ROWS       = 25,
  parameter int MAX_PARAMS = 8
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic       operation_i,
  input  wire logic [7:0] data_byte_i,
  input  wire logic [6:0] read_column_i,
  input  wire logic [4:0] read_row_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      cell_char_o,
  output logic [7:0]      cell_attribute_o,
  output logic [6:0]      cursor_column_o,
  output logic [4:0]      cursor_row_o,
  output logic            halted_o
);
  localparam int Cells = COLUMNS * ROWS;
  localparam int AW    = $clog2(Cells);
  localparam int PW    = $clog2(MAX_PARAMS);
  localparam int CW    = $clog2(MAX_PARAMS + 1);
  localparam logic [AW-1:0] LastCell = AW'(Cells - 1);
  localparam logic [6:0] ColMax = 7'(COLUMNS);
  localparam logic [4:0] RowMax = 5'(ROWS);

  typedef enum logic [7:0] {
    ST_INIT  = 8'b0000_0001,
    ST_IDLE  = 8'b0000_0010,
    ST_ADDR  = 8'b0000_0100,
    ST_RWAIT = 8'b0000_1000,
    ST_SGR   = 8'b0001_0000,
    ST_CLEAR = 8'b0010_0000,
    ST_OUT   = 8'b0100_0000,
    ST_RDATA = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic [AW-1:0] addr_q, addr_d;
  logic [AW-1:0] end_q, end_d;
  logic [6:0] col_q, col_d, scol_q, scol_d;
  logic [4:0] line_q, line_d, sline_q, sline_d;
  logic [7:0] attr_q, attr_d;
  logic       invis_q, invis_d, halt_q, halt_d;
  parse_e     ps_q, ps_d;
  logic [9:0] pv_q [MAX_PARAMS];
  logic [9:0] pv_d [MAX_PARAMS];
  logic [CW-1:0] pc_q, pc_d;
  logic [1:0] dc_q, dc_d;
  logic [PW-1:0] si_q, si_d;
  logic       op_q, op_d, inr_q, inr_d;
  logic [7:0] byte_q, byte_d;
  logic [6:0] rc_q, rc_d;
  logic [4:0] rr_q, rr_d;
  logic [7:0] oc_q, oc_d, oa_q, oa_d;
  logic       ov_q, ov_d;
  logic       text_walk_q, text_walk_d;

  logic       cwe, awe;
  logic [7:0] cwd, awd, crd, ard;

  aets_ram #(.Width(8), .Depth(Cells)) u_char (
    .clk_i(clk_i), .we_i(cwe), .addr_i(addr_q), .wdata_i(cwd), .rdata_o(crd));
  aets_ram #(.Width(8), .Depth(Cells)) u_attr (
    .clk_i(clk_i), .we_i(awe), .addr_i(addr_q), .wdata_i(awd), .rdata_o(ard));

  logic accept;
  assign accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE) || ov_q;

  // Parameter access helpers.
  logic [CW:0] used;
  logic [9:0]  p0, p1, cnt0, sgr_c;
  logic [7:0]  sgr_a;
  logic        sgr_inv;
  logic [11:0] tmp_l, tmp_c, mac;
  logic [AW-1:0] cur_idx;

  always_comb begin
    used = (CW + 1)'(pc_q) + 1'b1;
    if (used > (CW + 1)'(MAX_PARAMS)) used = (CW + 1)'(MAX_PARAMS);
    p0 = pv_q[0];
    p1 = (used > (CW + 1)'(1)) ? pv_q[1] : 10'd0;
    cnt0 = (p0 == 10'd0) ? 10'd1 : p0;
    sgr_c = pv_q[si_q];
    cur_idx = AW'(line_q - 5'd1) * AW'(COLUMNS) + AW'(col_q - 7'd1);
    mac = 12'(pv_q[PW'(pc_q)]) * 12'd10 + 12'(byte_q - 8'd48);
  end

  // Shared attribute unit: applies one SGR code per cycle.
  always_comb begin
    sgr_a = attr_q;
    sgr_inv = invis_q;
    if (sgr_c == 10'd0) sgr_a = AttrDefault;
    else if (sgr_c == 10'd1) sgr_a = attr_q | AttrIntense;
    else if (sgr_c == 10'd5) sgr_a = attr_q | AttrBlink;
    else if (sgr_c == 10'd7) sgr_a = {attr_q[3:0], attr_q[7:4]};
    else if (sgr_c == 10'd8) sgr_inv = 1'b1;
    else if (sgr_c >= 10'd30 && sgr_c <= 10'd37)
      sgr_a = (attr_q & ForeKeep) | {5'd0, colour_bits(3'(sgr_c - 10'd30))};
    else if (sgr_c >= 10'd40 && sgr_c <= 10'd47)
      sgr_a = (attr_q & BackKeep) | {1'b0, colour_bits(3'(sgr_c - 10'd40)), 4'd0};
  end

  // Sequencer.
  always_comb begin
    state_d = state_q; addr_d = addr_q; end_d = end_q;
    col_d = col_q; line_d = line_q; scol_d = scol_q; sline_d = sline_q;
    attr_d = attr_q; invis_d = invis_q; halt_d = halt_q; ps_d = ps_q;
    pv_d = pv_q; pc_d = pc_q; dc_d = dc_q; si_d = si_q;
    op_d = op_q; inr_d = inr_q; byte_d = byte_q; rc_d = rc_q; rr_d = rr_q;
    oc_d = oc_q; oa_d = oa_q; ov_d = ov_q;
    cwe = 1'b0; awe = 1'b0; cwd = SpaceByte; awd = 8'd0;
    tmp_l = 12'd0; tmp_c = 12'd0;
    if (ov_q && !out_stall_i) ov_d = 1'b0;
    unique case (state_q)
      ST_INIT: begin
        cwe = 1'b1; awe = 1'b1;
        if (addr_q == LastCell) state_d = ST_IDLE;
        else addr_d = addr_q + 1'b1;
      end
      ST_IDLE: begin
        if (accept) begin
          op_d = operation_i; byte_d = data_byte_i;
          rc_d = read_column_i; rr_d = read_row_i;
          inr_d = (read_column_i < ColMax) && (read_row_i < RowMax);
          state_d = ST_ADDR;
        end
      end
      ST_ADDR: begin
        state_d = ST_OUT;
        oc_d = 8'd0; oa_d = 8'd0;
        if (op_q == OpRead) begin
          addr_d = AW'(rr_q) * AW'(COLUMNS) + AW'(rc_q);
          state_d = ST_RWAIT;
        end else if (halt_q) begin
          state_d = ST_OUT;
        end else if (ps_q == PS_ESC) begin
          if (byte_q == 8'd91) begin
            ps_d = PS_CSI;
            for (int i = 0; i < MAX_PARAMS; i++) pv_d[i] = 10'd0;
            pc_d = '0; dc_d = 2'd0;
          end else ps_d = PS_TEXT;
        end else if (ps_q == PS_CSI) begin
          if (byte_q >= 8'd48 && byte_q <= 8'd57) begin
            if (dc_q < 2'd3) begin
              if (pc_q < CW'(MAX_PARAMS)) pv_d[PW'(pc_q)] = mac[9:0];
              dc_d = dc_q + 2'd1;
            end
          end else if ((byte_q >= 8'd65 && byte_q <= 8'd90) ||
                       (byte_q >= 8'd97 && byte_q <= 8'd122)) begin
            ps_d = PS_TEXT;
            case (byte_q)
              8'd72, 8'd102: begin
                line_d = (p0 == 10'd0) ? 5'd1 : (p0 > 10'(ROWS)) ? RowMax : 5'(p0);
                col_d = (p1 == 10'd0) ? 7'd1 : (p1 > 10'(COLUMNS)) ? ColMax : 7'(p1);
              end
              8'd65: begin
                tmp_l = 12'(line_q) - 12'(cnt0);
                line_d = (tmp_l[11] || tmp_l == 12'd0) ? 5'd1 : 5'(tmp_l);
              end
              8'd66: begin
                tmp_l = 12'(line_q) + 12'(cnt0);
                line_d = (tmp_l > 12'(ROWS)) ? RowMax : 5'(tmp_l);
              end
              8'd67: begin
                tmp_c = 12'(col_q) + 12'(cnt0);
                col_d = (tmp_c > 12'(COLUMNS)) ? ColMax : 7'(tmp_c);
              end
              8'd68: begin
                tmp_c = 12'(col_q) - 12'(cnt0);
                col_d = (tmp_c[11] || tmp_c == 12'd0) ? 7'd1 : 7'(tmp_c);
              end
              8'd115: begin scol_d = col_q; sline_d = line_q; end
              8'd117: begin col_d = scol_q; line_d = sline_q; end
              8'd74: begin
                addr_d = '0; end_d = LastCell;
                col_d = 7'd1; line_d = 5'd1;
                state_d = ST_CLEAR;
              end
              8'd75: begin
                addr_d = cur_idx;
                end_d = AW'(line_q - 5'd1) * AW'(COLUMNS) + AW'(COLUMNS - 1);
                col_d = ColMax;
                state_d = ST_CLEAR;
              end
              8'd109: begin si_d = '0; state_d = ST_SGR; end
              default: ;
            endcase
          end else begin
            dc_d = 2'd0;
            if (pc_q < CW'(MAX_PARAMS)) pc_d = pc_q + 1'b1;
          end
        end else if (byte_q == EscByte) begin
          ps_d = PS_ESC;
        end else begin
          ps_d = PS_TEXT;
          if (byte_q == LfByte) begin
            col_d = 7'd1; line_d = line_q + 5'd1;
          end else begin
            addr_d = cur_idx;
            state_d = ST_CLEAR; end_d = cur_idx;
            if (col_q >= ColMax) begin
              col_d = 7'd1; line_d = line_q + 5'd1;
            end else col_d = col_q + 7'd1;
          end
          if (line_d > RowMax) begin
            line_d = RowMax + 5'd1; halt_d = 1'b1;
          end
        end
      end
      ST_CLEAR: begin
        // Walks the cell range; a walk for a text byte stores that byte.
        cwe = 1'b1;
        if (text_walk_q) begin
          cwd = byte_q; awe = !invis_q; awd = attr_q;
        end
        if (addr_q == end_q) state_d = ST_OUT;
        else addr_d = addr_q + 1'b1;
      end
      ST_SGR: begin
        attr_d = sgr_a; invis_d = sgr_inv;
        if ((CW + 1)'(si_q) + 1'b1 >= used) state_d = ST_OUT;
        else si_d = si_q + 1'b1;
      end
      ST_RWAIT: state_d = ST_RDATA;
      ST_RDATA: begin
        oc_d = inr_q ? crd : 8'd0;
        oa_d = inr_q ? ard : 8'd0;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        ov_d = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ps_q is PS_TEXT after letters too, so a letter walk must not store text.
  assign text_walk_d = (state_q == ST_ADDR) ? (state_d == ST_CLEAR &&
                        ps_q == PS_TEXT && op_q == OpFeed) : text_walk_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT; addr_q <= '0; end_q <= '0;
      col_q <= 7'd1; line_q <= 5'd1; scol_q <= 7'd1; sline_q <= 5'd1;
      attr_q <= 8'd0; invis_q <= 1'b0; halt_q <= 1'b0; ps_q <= PS_TEXT;
      for (int i = 0; i < MAX_PARAMS; i++) pv_q[i] <= 10'd0;
      pc_q <= '0; dc_q <= 2'd0; si_q <= '0; ov_q <= 1'b0;
      text_walk_q <= 1'b0;
    end else begin
      state_q <= state_d; addr_q <= addr_d; end_q <= end_d;
      col_q <= col_d; line_q <= line_d; scol_q <= scol_d; sline_q <= sline_d;
      attr_q <= attr_d; invis_q <= invis_d; halt_q <= halt_d; ps_q <= ps_d;
      pv_q <= pv_d; pc_q <= pc_d; dc_q <= dc_d; si_q <= si_d; ov_q <= ov_d;
      text_walk_q <= text_walk_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    op_q <= op_d;
    inr_q <= inr_d; byte_q <= byte_d; rc_q <= rc_d; rr_q <= rr_d;
    oc_q <= oc_d; oa_q <= oa_d;
  end

  assign out_valid_o      = ov_q;
  assign cell_char_o      = oc_q;
  assign cell_attribute_o = oa_q;
  assign cursor_column_o  = col_q;
  assign cursor_row_o     = line_q;
  assign halted_o         = halt_q;
endmodule
`default_nettype wire

// ===== rtl/core/aets_checker.sv =====
// Port-level checker for the ANSI text screen unit, with its bind.
`default_nettype none
`include "ansi_escape_text_screen_unit_macros.svh"
module aets_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [4:0] cursor_row_o,
  input wire logic       halted_o
);
  `AETS_ASSERT_NEXT(a_no_take_while_busy, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o, "beat taken while busy")
  `AETS_ASSERT_NEXT(a_out_holds, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o, "stalled beat dropped")
  `AETS_ASSERT_NEXT(a_halt_sticks, clk_i, rst_ni, halted_o, halted_o, "halt flag cleared")
  `AETS_ASSERT_IMP(a_row_nonzero, clk_i, rst_ni, 1'b1, cursor_row_o != 5'd0, "cursor row zero")
endmodule

bind ansi_escape_text_screen_unit aets_checker u_aets_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
  .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
  .cursor_row_o(cursor_row_o), .halted_o(halted_o));
`default_nettype wire

// ===== tb/ansi_escape_text_screen_unit_checker.sv =====
// Checker that predicts and compares the output beats of the text screen unit.
`timescale 1ns / 1ps
module ansi_escape_text_screen_unit_checker
  import aets_pkg::*;
#(
  parameter int COLUMNS    = 80,
  parameter int ROWS       = 25,
  parameter int MAX_PARAMS = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic       operation_i,
  input  logic [7:0] data_byte_i,
  input  logic [6:0] read_column_i,
  input  logic [4:0] read_row_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic [7:0] cell_char_i,
  input  logic [7:0] cell_attribute_i,
  input  logic [6:0] cursor_column_i,
  input  logic [4:0] cursor_row_i,
  input  logic       halted_i,
  output int         fail_count_o,
  output int         pending_o
);

  typedef struct packed {
    logic [7:0] ch;
    logic [7:0] attr;
    logic [6:0] col;
    logic [4:0] row;
    logic       halt;
  } screen_beat_t;

  localparam int Cells = COLUMNS * ROWS;

  // Predicted screen state.
  logic [7:0] chars [Cells];
  logic [7:0] attrs [Cells];
  int         cur_col, cur_row, mark_col, mark_row;
  logic [7:0] pen_attr;
  logic       hidden, stopped;
  parse_e     pstate;
  int         params [MAX_PARAMS];
  int         n_params, n_digits;

  screen_beat_t expected_beats [$];

  initial begin
    for (int i = 0; i < Cells; i++) begin
      chars[i] = SpaceByte;
      attrs[i] = '0;
    end
    cur_col = 1; cur_row = 1; mark_col = 1; mark_row = 1;
    pen_attr = '0; hidden = 0; stopped = 0; pstate = PS_TEXT;
    for (int i = 0; i < MAX_PARAMS; i++) params[i] = 0;
    n_params = 0; n_digits = 0;
    fail_count_o = 0;
  end

  assign pending_o = expected_beats.size();

  function automatic int clip(int v, int hi);
    return (v < 1) ? 1 : (v > hi) ? hi : v;
  endfunction

  function automatic int param_or_zero(int i);
    int used;
    used = (n_params + 1 > MAX_PARAMS) ? MAX_PARAMS : n_params + 1;
    return (i < used) ? params[i] : 0;
  endfunction

  function automatic int step_count();
    return (param_or_zero(0) == 0) ? 1 : param_or_zero(0);
  endfunction

  function automatic logic [2:0] rgb_of(int c);
    logic [2:0] v;
    v = c[2:0];
    return {v[0], v[1], v[2]};
  endfunction

  task automatic apply_sgr(int c);
    logic [7:0] a;
    a = pen_attr;
    if (c == 0) a = AttrDefault;
    else if (c == 1) a = a | AttrIntense;
    else if (c == 5) a = a | AttrBlink;
    else if (c == 7) a = {a[3:0], a[7:4]};
    else if (c == 8) hidden = 1;
    else if (c >= 30 && c <= 37) a = (a & ForeKeep) | {5'd0, rgb_of(c - 30)};
    else if (c >= 40 && c <= 47) a = (a & BackKeep) | {1'b0, rgb_of(c - 40), 4'd0};
    pen_attr = a;
  endtask

  task automatic end_sequence(logic [7:0] letter);
    int used;
    case (letter)
      "H", "f": begin
        cur_row = clip(param_or_zero(0), ROWS);
        cur_col = clip(param_or_zero(1), COLUMNS);
      end
      "A": cur_row = clip(cur_row - step_count(), ROWS);
      "B": cur_row = clip(cur_row + step_count(), ROWS);
      "C": cur_col = clip(cur_col + step_count(), COLUMNS);
      "D": cur_col = clip(cur_col - step_count(), COLUMNS);
      "s": begin mark_col = cur_col; mark_row = cur_row; end
      "u": begin cur_col = mark_col; cur_row = mark_row; end
      "J": begin
        for (int i = 0; i < Cells; i++) chars[i] = SpaceByte;
        cur_col = 1; cur_row = 1;
      end
      "K": begin
        for (int i = cur_col - 1; i < COLUMNS; i++)
          chars[(cur_row - 1) * COLUMNS + i] = SpaceByte;
        cur_col = COLUMNS;
      end
      "m": begin
        used = (n_params + 1 > MAX_PARAMS) ? MAX_PARAMS : n_params + 1;
        for (int i = 0; i < used; i++) apply_sgr(params[i]);
      end
      default: ;
    endcase
  endtask

  task automatic write_text(logic [7:0] b);
    int idx;
    if (b == LfByte) begin
      cur_col = 1;
      cur_row++;
    end else begin
      idx = (cur_row - 1) * COLUMNS + cur_col - 1;
      chars[idx] = b;
      if (!hidden) attrs[idx] = pen_attr;
      cur_col++;
      if (cur_col > COLUMNS) begin
        cur_col = 1;
        cur_row++;
      end
    end
    if (cur_row > ROWS) begin
      cur_row = ROWS + 1;
      stopped = 1;
    end
  endtask

  // Parser step for one fed byte.
  task automatic feed_byte(logic [7:0] b);
    if (stopped) return;
    if (pstate == PS_ESC) begin
      if (b == "[") begin
        pstate = PS_CSI;
        for (int i = 0; i < MAX_PARAMS; i++) params[i] = 0;
        n_params = 0; n_digits = 0;
      end else pstate = PS_TEXT;
    end else if (pstate == PS_CSI) begin
      if (b >= "0" && b <= "9") begin
        if (n_digits < 3) begin
          if (n_params < MAX_PARAMS) params[n_params] = params[n_params] * 10 + (b - "0");
          n_digits++;
        end
      end else if ((b >= "A" && b <= "Z") || (b >= "a" && b <= "z")) begin
        pstate = PS_TEXT;
        end_sequence(b);
      end else begin
        n_digits = 0;
        if (n_params < MAX_PARAMS) n_params++;
      end
    end else if (b == EscByte) pstate = PS_ESC;
    else write_text(b);
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    fail_count_o++;
  endtask

  // Predict on each accepted input beat and compare each delivered output beat.
  always @(posedge clk_i) begin
    screen_beat_t e;
    if (rst_ni && in_valid_i && !in_stall_i) begin
      e = '0;
      if (operation_i == OpRead) begin
        if (read_column_i < COLUMNS && read_row_i < ROWS) begin
          e.ch = chars[read_row_i * COLUMNS + read_column_i];
          e.attr = attrs[read_row_i * COLUMNS + read_column_i];
        end
      end else feed_byte(data_byte_i);
      e.col = cur_col[6:0];
      e.row = cur_row[4:0];
      e.halt = stopped;
      expected_beats.push_back(e);
    end
    if (rst_ni && out_valid_i && !out_stall_i) begin
      if (expected_beats.size() == 0) begin
        $display("%0t: output beat with nothing expected", $realtime);
        fail_count_o++;
      end else begin
        e = expected_beats.pop_front();
        if (cell_char_i !== e.ch) report_mismatch("cell_char", cell_char_i, e.ch);
        if (cell_attribute_i !== e.attr)
          report_mismatch("cell_attribute", cell_attribute_i, e.attr);
        if (cursor_column_i !== e.col) report_mismatch("cursor_column", cursor_column_i, e.col);
        if (cursor_row_i !== e.row) report_mismatch("cursor_row", cursor_row_i, e.row);
        if (halted_i !== e.halt) report_mismatch("halted", halted_i, e.halt);
      end
    end
  end

endmodule

// ===== tb/tb_ansi_escape_text_screen_unit.sv =====
// Testbench top of the text screen unit: stimulus, clock, reset and verdict.
`timescale 1ns / 1ps
module tb_ansi_escape_text_screen_unit;
  import aets_pkg::*;

  logic       clk_i = 0, rst_ni = 0;
  logic       in_valid_i = 0, in_stall_o;
  logic       operation_i = OpFeed;
  logic [7:0] data_byte_i = '0;
  logic [6:0] read_column_i = '0;
  logic [4:0] read_row_i = '0;
  logic       out_valid_o, out_stall_i = 0;
  logic [7:0] cell_char_o, cell_attribute_o;
  logic [6:0] cursor_column_o;
  logic [4:0] cursor_row_o;
  logic       halted_o;
  int         fail_count, pending;
  int         send_idle_pct = 0, recv_stall_pct = 0;

  ansi_escape_text_screen_unit u_dut (.*);

  ansi_escape_text_screen_unit_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .operation_i, .data_byte_i,
    .read_column_i, .read_row_i, .out_valid_i(out_valid_o), .out_stall_i,
    .cell_char_i(cell_char_o), .cell_attribute_i(cell_attribute_o),
    .cursor_column_i(cursor_column_o), .cursor_row_i(cursor_row_o), .halted_i(halted_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Receiver stalls at random, changed on the falling edge.
  always @(negedge clk_i) out_stall_i <= ($urandom_range(99) < recv_stall_pct);

  // Send one beat and wait for it to be accepted; valid drops only while idling.
  task automatic send_beat(logic op, logic [7:0] b, logic [6:0] c, logic [4:0] r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 0;
      @(negedge clk_i);
    end
    in_valid_i <= 1; operation_i <= op; data_byte_i <= b;
    read_column_i <= c; read_row_i <= r;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic feed_text(string s);
    for (int i = 0; i < s.len(); i++) send_beat(OpFeed, s[i], '0, '0);
  endtask

  task automatic read_cell(int c, int r);
    send_beat(OpRead, 8'($urandom), c[6:0], r[4:0]);
  endtask

  // Random sequence: escape sequences with random content, text, reads and noise.
  task automatic random_beat();
    int k;
    string s;
    k = $urandom_range(99);
    if (k < 35) begin
      s = "\033[";
      repeat ($urandom_range(3)) begin
        if ($urandom_range(3) == 0) s = {s, $sformatf("%0d", $urandom_range(9999))};
        else s = {s, $sformatf("%0d", $urandom_range(49))};
        s = {s, ($urandom_range(4) == 0) ? " " : ";"};
      end
      case ($urandom_range(12))
        0: s = {s, "H"}; 1: s = {s, "f"}; 2: s = {s, "A"}; 3: s = {s, "B"};
        4: s = {s, "C"}; 5: s = {s, "D"}; 6: s = {s, "s"}; 7: s = {s, "u"};
        8: s = {s, ($urandom_range(5) == 0) ? "J" : "m"}; 9: s = {s, "K"};
        10: s = {s, "m"}; 11: s = {s, "z"};
        default: s = {s, "m"};
      endcase
      feed_text(s);
    end else if (k < 65) begin
      send_beat(OpFeed, 8'($urandom_range(32, 126)), 7'($urandom), 5'($urandom));
    end else if (k < 88) read_cell($urandom_range(79), $urandom_range(24));
    else if (k < 92) read_cell($urandom_range(127), $urandom_range(31));
    else if (k < 94) send_beat(OpFeed, LfByte, '0, '0);
    else send_beat(OpFeed, 8'($urandom), 7'($urandom), 5'($urandom));
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1;
    // Directed part: colors, attributes, cursor moves, clears and reads.
    feed_text("\033[0;1;5;31;42mA\033[7mB\033[4;99mC");
    feed_text("\033[5;10Hx\033[2A\033[B\033[999C\033[D\033[0Dq");
    feed_text("\033[s\033[12345;3fy\033[u\033[Kz\033X!\033[1;2;3;4;5;6;7;8;9;0m");
    read_cell(0, 0); read_cell(1, 0); read_cell(9, 4); read_cell(79, 4);
    read_cell(127, 31); read_cell(80, 0); read_cell(0, 25);
    send_beat(OpFeed, 8'hff, 7'h7f, 5'h1f); send_beat(OpFeed, 8'h00, '0, '0);
    feed_text("\033[8mI\033[0mJ\033[J");
    // Random part with several idle profiles.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1) ? 64 : (ph == 3) ? 25 : 0;
      recv_stall_pct = (ph == 2) ? 64 : (ph == 3) ? 25 : 0;
      for (int n = 0; n < 60; n++) begin
        random_beat();
        // Once, in the last phase, run off the bottom to reach the halted state late in it.
        if (ph == 3 && n == 48) feed_text("\033[25;1H\n");
      end
    end
    send_idle_pct = 0;
    repeat (4) read_cell($urandom_range(79), $urandom_range(24));
    in_valid_i <= 0;
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #100ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/aets_pkg.sv
rtl/core/aets_ram.sv
rtl/core/ansi_escape_text_screen_unit.sv
rtl/core/aets_checker.sv
tb/ansi_escape_text_screen_unit_checker.sv
tb/tb_ansi_escape_text_screen_unit.sv
